// ----- src/assert_macros.svh -----
// Assertion macros for the checker file of this block.
// Needs only a clock and an active-low reset at the place of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/tcpd_pkg.sv -----
// Types and codes of the two-class priority task dispatcher.
// No dependencies; imported by every module of the block.
package tcpd_pkg;

  localparam int unsigned IdW   = 16;
  localparam int unsigned CfgIw = 2;
  localparam int unsigned CfgDw = 9;
  localparam int unsigned NumQ  = 4;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_FETCH  = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_QUEUED   = 3'd0,
    ST_INLINE   = 3'd1,
    ST_FULL     = 3'd2,
    ST_FETCHED  = 3'd3,
    ST_NONE     = 3'd4,
    ST_REMOVED  = 3'd5,
    ST_NOTFOUND = 3'd6
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  localparam logic [1:0] USE_MULTI = 2'd0;
  localparam logic [1:0] USE_MAIN  = 2'd1;

  localparam logic [CfgIw-1:0] REG_WORKERS = 2'd0;
  localparam logic [CfgIw-1:0] REG_CORES   = 2'd1;

  typedef struct packed {
    logic push;
    logic pop;
    logic del;
  } row_ctl_t;

endpackage

// ----- src/tcpd_cell.sv -----
// One queue cell: a stored task id with its occupancy bit.
// Depends on tcpd_pkg; instantiated in a row by tcpd_row.
module tcpd_cell import tcpd_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  row_ctl_t       ctl_i,
  input  logic [IdW-1:0] id_i,
  input  logic           left_occ_i,
  input  logic           right_occ_i,
  input  logic [IdW-1:0] right_data_i,
  input  logic           hit_i,
  output logic           hit_o,
  output logic           occ_o,
  output logic [IdW-1:0] data_o
);

  logic           occ_q, occ_d;
  logic [IdW-1:0] data_q, data_d;
  logic           shift, load;

  assign hit_o = hit_i | (occ_q & (data_q == id_i));
  assign shift = ctl_i.pop | (ctl_i.del & hit_o);
  assign load  = ctl_i.push & ~occ_q & left_occ_i;

  always_comb begin
    occ_d  = occ_q;
    data_d = data_q;
    if (shift) begin
      occ_d  = right_occ_i;
      data_d = right_data_i;
    end else if (load) begin
      occ_d  = 1'b1;
      data_d = id_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign occ_o  = occ_q;
  assign data_o = data_q;

endmodule

// ----- src/tcpd_row.sv -----
// One task queue as a row of cells that shift towards the head.
// Depends on tcpd_pkg and tcpd_cell.
module tcpd_row import tcpd_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  row_ctl_t       ctl_i,
  input  logic [IdW-1:0] id_i,
  output logic [IdW-1:0] head_o,
  output logic           empty_o,
  output logic           full_o,
  output logic           found_o
);

  logic           occ  [DEPTH];
  logic [IdW-1:0] data [DEPTH];
  logic           hit  [DEPTH+1];

  assign hit[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic           left_occ;
    logic           right_occ;
    logic [IdW-1:0] right_data;

    if (i == 0) begin : g_first
      assign left_occ = 1'b1;
    end else begin : g_mid
      assign left_occ = occ[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_occ  = 1'b0;
      assign right_data = data[i];
    end else begin : g_inner
      assign right_occ  = occ[i+1];
      assign right_data = data[i+1];
    end

    tcpd_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl_i),
      .id_i        (id_i),
      .left_occ_i  (left_occ),
      .right_occ_i (right_occ),
      .right_data_i(right_data),
      .hit_i       (hit[i]),
      .hit_o       (hit[i+1]),
      .occ_o       (occ[i]),
      .data_o      (data[i])
    );
  end

  assign head_o  = data[0];
  assign empty_o = ~occ[0];
  assign full_o  = occ[DEPTH-1];
  assign found_o = hit[DEPTH];

endmodule

// ----- src/two_class_priority_task_dispatcher.sv -----
// Top level of the two-class priority task dispatcher.
// Depends on tcpd_pkg and tcpd_row.
//
// Requests arrive on the s_axis channel: tuser carries the command (add, fetch,
// remove) and tdata the task id, priority, class and usage mode. Each request
// gives exactly one response on the m_axis channel: tuser carries the status
// and tdata the fetched or echoed task id.
// A request is registered in the accepting cycle and executed in the next,
// when all cells of the four queues compare their id in parallel and a
// first-match flag ripples along each row before the row shifts. The
// response is loaded into the output register at the end of execution, so
// a new request is not taken before the previous one has executed.
// The response register decouples the sides: a new request is accepted while
// the previous response is being taken, but not while it is stalled.
// Reset empties all queues, clears the fetch parity, sets the worker count to
// zero and the core count to one. Register writes on the cfg channel are
// always taken; index 0 is the worker count, index 1 the core count.
module two_class_priority_task_dispatcher import tcpd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [23:0]      s_axis_tdata,  // task_ident, high_priority, may_hang, usage_mode
  input  logic [1:0]       s_axis_tuser,  // command
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // task_out
  output logic [2:0]       m_axis_tuser,  // status
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CfgIw-1:0] cfg_index_i,
  input  logic [CfgDw-1:0] cfg_data_i
);

  state_e         state_q, state_d;
  cmd_e           cmd_q;
  logic [IdW-1:0] id_q;
  logic           high_q, hang_q;
  logic [1:0]     usage_q;
  logic           parity_q, parity_d;
  logic [7:0]     workers_q;
  logic [8:0]     cores_q;
  logic           out_valid_q;
  status_e        status_q, status_d;
  logic [IdW-1:0] res_q, res_d;
  logic           load_out, in_acc;

  row_ctl_t       ctl   [NumQ];
  logic [IdW-1:0] head  [NumQ];
  logic           empty [NumQ];
  logic           full  [NumQ];
  logic           found [NumQ];

  logic [1:0]     q_add, q_first, q_second, q_hi, q_lo;
  logic           special, run_inline;

  assign s_axis_tready = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  for (genvar q = 0; q < NumQ; q++) begin : g_row
    tcpd_row #(.DEPTH(QUEUE_DEPTH)) u_row (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl[q]),
      .id_i   (id_q),
      .head_o (head[q]),
      .empty_o(empty[q]),
      .full_o (full[q]),
      .found_o(found[q])
    );
  end

  assign q_add      = {hang_q, ~high_q};
  assign special    = ~parity_q & hang_q;
  assign q_first    = {hang_q, special};
  assign q_second   = {hang_q, ~special};
  assign q_hi       = {hang_q, 1'b0};
  assign q_lo       = {hang_q, 1'b1};
  assign run_inline = (workers_q == 8'd0) || (usage_q == USE_MAIN) ||
                      ((cores_q == 9'd1) && (usage_q == USE_MULTI) && !hang_q);

  always_comb begin
    state_d  = state_q;
    parity_d = parity_q;
    load_out = 1'b0;
    status_d = ST_NONE;
    res_d    = '0;
    for (int q = 0; q < NumQ; q++) begin
      ctl[q] = '0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d  = S_IDLE;
        load_out = 1'b1;
        unique case (cmd_q)
          CMD_ADD: begin
            res_d = id_q;
            if (run_inline) begin
              status_d = ST_INLINE;
            end else if (full[q_add]) begin
              status_d = ST_FULL;
            end else begin
              status_d         = ST_QUEUED;
              ctl[q_add].push  = 1'b1;
            end
          end
          CMD_FETCH: begin
            parity_d = ~parity_q;
            if (!empty[q_first]) begin
              status_d          = ST_FETCHED;
              res_d             = head[q_first];
              ctl[q_first].pop  = 1'b1;
            end else if (!empty[q_second]) begin
              status_d          = ST_FETCHED;
              res_d             = head[q_second];
              ctl[q_second].pop = 1'b1;
            end
          end
          CMD_REMOVE: begin
            res_d = id_q;
            if (found[q_hi]) begin
              status_d       = ST_REMOVED;
              ctl[q_hi].del  = 1'b1;
            end else if (found[q_lo]) begin
              status_d       = ST_REMOVED;
              ctl[q_lo].del  = 1'b1;
            end else begin
              status_d       = ST_NOTFOUND;
            end
          end
          default: begin
            status_d = ST_NONE;
          end
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      parity_q    <= 1'b0;
      workers_q   <= 8'd0;
      cores_q     <= 9'd1;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      parity_q <= parity_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == REG_WORKERS) begin
          workers_q <= cfg_data_i[7:0];
        end else if (cfg_index_i == REG_CORES) begin
          cores_q <= cfg_data_i;
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q   <= cmd_e'(s_axis_tuser);
      id_q    <= s_axis_tdata[15:0];
      high_q  <= s_axis_tdata[16];
      hang_q  <= s_axis_tdata[17];
      usage_q <= s_axis_tdata[19:18];
    end
    if (load_out) begin
      status_q <= status_d;
      res_q    <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_q;
  assign m_axis_tuser  = status_q;

endmodule

// ----- src/tcpd_checker.sv -----
// Port-level checker of the two-class priority task dispatcher and its bind.
// Depends on tcpd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tcpd_checker import tcpd_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  logic s_acc;
  logic none_resp;
  assign s_acc     = s_axis_tvalid && s_axis_tready;
  assign none_resp = m_axis_tvalid && (m_axis_tuser == ST_NONE);

  `ASSERT_NEXT(a_resp_held, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, s_acc, !s_axis_tready)
  `ASSERT_NEXT(a_resp_follows, clk_i, rst_ni, s_acc, ##1 m_axis_tvalid)
  `ASSERT_IMPLY(a_status_legal, clk_i, rst_ni, m_axis_tvalid, m_axis_tuser != 3'd7)
  `ASSERT_IMPLY(a_none_zero, clk_i, rst_ni, none_resp, m_axis_tdata == 16'd0)

endmodule

bind two_class_priority_task_dispatcher tcpd_checker u_tcpd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
